### rtl/core/tsl_pkg.sv
// Shared constants and types for the table search block.
`default_nettype none
package tsl_pkg;

  localparam int DATA_W          = 32;
  localparam int INDEX_W         = 8;
  localparam int COUNT_W         = 9;
  localparam int OP_W            = 2;
  localparam int DEF_TABLE_DEPTH = 256;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_LINEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_BINARY = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage
`default_nettype wire

### rtl/core/tsl_table.sv
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module tsl_table #(
  parameter int TABLE_DEPTH = tsl_pkg::DEF_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire tsl_pkg::data_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output tsl_pkg::data_t      rdata
);
  import tsl_pkg::*;

  data_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/table_search_linear_binary.sv
// Top level of the table search block: sequencer, shared comparator, result register.
//
//   channel   | handshake           | beat contents
//   ----------+---------------------+------------------------------------------
//   input     | in_valid / in_stall | operation, entry_index, value
//   output    | out_valid/out_stall | found, position
//   config    | entry_count_we      | entry_count_wdata (entry count, 9 bits)
//
// A load beat writes the table without leaving idle. A linear search issues the
// first read, then compares one entry per cycle through the single table read port,
// then hands over the result. A binary search runs bisection steps (read, then
// compare and move a bound); a miss ends with the read that finds the bounds
// crossed, then the result. Reset clears the sequencer, the entry count and the
// output valid; table contents stay undefined until loaded. Input stalls while a
// search runs; a finished result waits in the output register so the next beat
// can be taken.
`default_nettype none
module table_search_linear_binary #(
  parameter int TABLE_DEPTH = tsl_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         entry_count_we,
  input  wire logic [tsl_pkg::COUNT_W-1:0]  entry_count_wdata,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [tsl_pkg::OP_W-1:0]     operation,
  input  wire logic [tsl_pkg::INDEX_W-1:0]  entry_index,
  input  wire tsl_pkg::data_t               value,
  // output channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              found,
  output logic [tsl_pkg::INDEX_W-1:0]       position
);
  import tsl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_CMP    = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0]      entry_count;
  logic [COUNT_W-1:0]      used_count;
  logic                    is_binary;
  data_t                   key;
  logic [COUNT_W-1:0]      cur, cur_next;        // scan position or midpoint
  logic [COUNT_W-1:0]      low_bound, low_next;
  logic signed [COUNT_W:0] high_bound, high_next; // may drop to -1
  logic                    res_found, res_found_next;
  logic [INDEX_W-1:0]      res_pos, res_pos_next;

  logic                    in_take;
  logic                    out_free;
  logic [AW-1:0]           raddr;
  data_t                   rdata;
  logic                    load_we;

  // shared comparator
  logic                    cmp_eq;
  logic                    cmp_lt;
  logic [COUNT_W:0]        bound_sum;
  logic                    bounds_ok;
  logic [COUNT_W-1:0]      scan_inc;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // saturate the count to the table depth
  assign used_count = (32'(entry_count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : entry_count;

  // drop loads beyond the table
  assign load_we = in_take && (operation == OP_LOAD) && (32'(entry_index) < TABLE_DEPTH);

  assign cmp_eq    = (rdata == key);
  assign cmp_lt    = (rdata < key);
  assign bound_sum = {1'b0, low_bound} + $unsigned(high_bound);
  assign bounds_ok = $signed({1'b0, low_bound}) <= high_bound;
  assign scan_inc  = cur + COUNT_W'(1);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    low_next       = low_bound;
    high_next      = high_bound;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    raddr          = AW'(cur);
    unique case (state)
      S_IDLE: begin
        if (in_take && (operation == OP_LINEAR || operation == OP_BINARY)) begin
          cur_next   = '0;
          low_next   = '0;
          high_next  = $signed({1'b0, used_count}) - (COUNT_W+1)'(1);
          state_next = S_READ;
        end
      end
      S_READ: begin
        // issue the read for the current scan slot or the midpoint
        if (is_binary) begin
          cur_next = bound_sum[COUNT_W:1];
          raddr    = AW'(bound_sum[COUNT_W:1]);
          if (bounds_ok) begin
            state_next = S_CMP;
          end else begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            state_next     = S_RESULT;
          end
        end else if (cur < used_count) begin
          state_next = S_CMP;
        end else begin
          res_found_next = 1'b0;
          res_pos_next   = '0;
          state_next     = S_RESULT;
        end
      end
      S_CMP: begin
        if (cmp_eq) begin
          res_found_next = 1'b1;
          res_pos_next   = cur[INDEX_W-1:0];
          state_next     = S_RESULT;
        end else if (is_binary) begin
          if (cmp_lt) begin
            low_next = scan_inc;
          end else begin
            high_next = $signed({1'b0, cur}) - (COUNT_W+1)'(1);
          end
          state_next = S_READ;
        end else begin
          // advance the scan and read the next slot in the same cycle
          cur_next = scan_inc;
          raddr    = AW'(scan_inc);
          if (scan_inc >= used_count) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            state_next     = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
      cur         <= '0;
      low_bound   <= '0;
      high_bound  <= '0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      low_bound  <= low_next;
      high_bound <= high_next;
      if (entry_count_we) begin
        entry_count <= entry_count_wdata;
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    if (in_take) begin
      key       <= value;
      is_binary <= (operation == OP_BINARY);
    end
    if (state == S_RESULT && out_free) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

  tsl_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(entry_index)),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
`default_nettype wire
